// ----- rtl/tcp_sender_window_retransmit_macros.svh -----
// Assertion macros used by the sender engine RTL.
`ifndef TCP_SENDER_WINDOW_RETRANSMIT_MACROS_SVH
`define TCP_SENDER_WINDOW_RETRANSMIT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TSW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true outside reset.
`define TSW_NEVER(lbl, clk, rstn, expr, msg) \
    `TSW_ASSERT(lbl, clk, rstn, !(expr), msg)

`endif

// ----- rtl/tsw_pkg.sv -----
// Types, sizes and codes for the TCP sender bookkeeping block.
package tsw_pkg;

    localparam int MAX_PAYLOAD   = 1452;
    localparam int MAX_RETRIES   = 8;
    localparam int PENDING_DEPTH = 64;
    localparam int RESULT_LIMIT  = 48;

    localparam int IDX_W  = $clog2(PENDING_DEPTH);
    localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 3);
    localparam int PAY_W  = 11;
    localparam int FL_W   = $clog2(PENDING_DEPTH * (MAX_PAYLOAD + 2) + 1);
    localparam int RA_W   = $clog2(RESULT_LIMIT);
    localparam int RN_W   = $clog2(RESULT_LIMIT + 1);
    localparam int OFF_W  = 64;
    localparam int PEND_W = OFF_W + LEN_W;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_FILL  = 3'd1,
        CMD_ACK   = 3'd2,
        CMD_TICK  = 3'd3,
        CMD_EMPTY = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        REG_ISEQ = 2'd0,
        REG_ITO  = 2'd1,
        REG_CAP  = 2'd2
    } t_reg;

    typedef struct packed {
        logic             has;
        logic [31:0]      seq;
        logic [PAY_W-1:0] pay;
        logic             syn;
        logic             fin;
        logic             rtx;
    } t_res;

    typedef struct packed {
        logic            we;
        logic [RA_W-1:0] addr;
        t_res            data;
    } t_rbuf_wr;

    typedef struct packed {
        logic            start;
        logic [RN_W-1:0] count;
        logic [FL_W-1:0] flight;
        logic [7:0]      retry;
        logic [15:0]     accepted;
    } t_flush;

endpackage

// ----- rtl/tsw_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module tsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/tsw_core.sv -----
// Sender engine: window fill, ack retirement and retransmit timer over the pending ring.
`include "tcp_sender_window_retransmit_macros.svh"

module tsw_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_command,
    input  logic [15:0]       i_write_count,
    input  logic              i_end_input,
    input  logic [31:0]       i_ack_number,
    input  logic [15:0]       i_peer_window,
    input  logic [15:0]       i_elapsed_ms,
    input  logic              i_out_busy,
    output tsw_pkg::t_rbuf_wr o_rbuf,
    output tsw_pkg::t_flush   o_flush
);
    import tsw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CMD, S_FSYN, S_FLOOP, S_FFIN, S_ARD, S_ACHK, S_AUPD,
        S_TRD, S_TEMIT, S_FIN
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_iseq, s_ito32;
    logic [15:0] r_ito, r_cap;

    logic [2:0]  r_cmd;
    logic [15:0] r_wcnt, r_win, r_elapsed;
    logic        r_eoi;
    logic [31:0] r_ackno;

    logic [OFF_W-1:0] r_next, n_next, r_hack, n_hack, r_hre, n_hre, r_ack_off, n_ack_off;
    logic [15:0] r_wl, n_wl, r_buf, n_buf, r_accepted, n_accepted;
    logic        r_wz, n_wz, r_fin_done, n_fin_done, r_trun, n_trun, r_ended, n_ended;
    logic [31:0] r_timer, n_timer, r_cto, n_cto;
    logic [7:0]  r_retry, n_retry;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [FL_W-1:0]  r_flight, n_flight;
    logic [RN_W-1:0]  r_nres, n_nres;

    // pending ring
    logic              s_pwe, s_pre;
    logic [IDX_W-1:0]  s_slot;
    logic [PEND_W-1:0] s_pwdata, s_prdata;
    logic [OFF_W-1:0]  s_q_off;
    logic [LEN_W-1:0]  s_q_len;

    // one send or resend this cycle
    logic             s_emit, s_track, s_acct;
    logic [31:0]      s_seq;
    logic [LEN_W-1:0] s_pay, s_len;
    logic             s_syn, s_fin, s_rtx;

    logic             s_room;
    logic [15:0]      s_n, s_space, s_buf_left;
    logic [31:0]      s_back;
    logic [OFF_W-1:0] s_right;
    logic [32:0]      s_tsum;
    logic [31:0]      s_tnew;
    logic [1:0]       s_flags;
    logic [CNT_W:0]   s_slot_sum;

    assign s_q_off = s_prdata[PEND_W-1 -: OFF_W];
    assign s_q_len = s_prdata[LEN_W-1:0];
    assign s_room  = (r_count < CNT_W'(PENDING_DEPTH)) && (r_nres < RN_W'(RESULT_LIMIT));
    assign s_slot_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
    assign s_slot = (s_slot_sum >= (CNT_W+1)'(PENDING_DEPTH))
                  ? IDX_W'(s_slot_sum - (CNT_W+1)'(PENDING_DEPTH)) : IDX_W'(s_slot_sum);

    tsw_ram #(.WIDTH(PEND_W), .DEPTH(PENDING_DEPTH)) u_pend (
        .i_clk  (i_clk),
        .i_we   (s_pwe),
        .i_waddr(s_slot),
        .i_wdata(s_pwdata),
        .i_re   (s_pre),
        .i_raddr(r_head),
        .o_rdata(s_prdata)
    );

    assign o_in_ready = (r_state == S_IDLE) && !i_out_busy;
    assign s_space    = (r_cap > r_buf) ? r_cap - r_buf : 16'd0;
    assign s_tsum     = {1'b0, r_timer} + 33'(r_elapsed);
    assign s_tnew     = s_tsum[32] ? 32'hFFFF_FFFF : s_tsum[31:0];
    assign s_right    = r_ack_off + OFF_W'(r_win);
    assign s_back     = (r_iseq + r_next[31:0]) - r_ackno;

    always_comb begin
        n_state = r_state;
        n_next = r_next; n_hack = r_hack; n_hre = r_hre; n_ack_off = r_ack_off;
        n_wl = r_wl; n_buf = r_buf; n_accepted = r_accepted;
        n_wz = r_wz; n_fin_done = r_fin_done; n_trun = r_trun; n_ended = r_ended;
        n_timer = r_timer; n_cto = r_cto; n_retry = r_retry;
        n_head = r_head; n_count = r_count; n_flight = r_flight; n_nres = r_nres;
        s_emit = 1'b0; s_track = 1'b0; s_acct = 1'b0; s_pre = 1'b0;
        s_seq = r_iseq + r_next[31:0];
        s_pay = '0; s_syn = 1'b0; s_fin = 1'b0; s_rtx = 1'b0;
        s_n = r_wl;
        s_buf_left = r_buf;
        s_flags = 2'd0;
        o_flush = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_out_busy) begin
                    n_state    = S_CMD;
                    n_nres     = '0;
                    n_accepted = '0;
                end
            end
            S_CMD: begin
                n_state = S_FIN;
                case (r_cmd)
                    CMD_WRITE: begin
                        if (!r_ended) begin
                            n_accepted = (r_wcnt < s_space) ? r_wcnt : s_space;
                            n_buf      = r_buf + ((r_wcnt < s_space) ? r_wcnt : s_space);
                            n_ended    = r_eoi;
                        end
                    end
                    CMD_FILL: n_state = S_FSYN;
                    CMD_ACK: begin
                        if (OFF_W'(s_back) <= r_next - r_hack) begin
                            n_ack_off = r_next - OFF_W'(s_back);
                            n_state   = S_ARD;
                        end
                    end
                    CMD_TICK: begin
                        if (r_trun && r_retry <= 8'(MAX_RETRIES)) begin
                            n_timer = s_tnew;
                            if (s_tnew >= r_cto && r_count != '0) begin
                                n_state = S_TRD;
                            end
                        end
                    end
                    CMD_EMPTY: s_emit = 1'b1;
                    default: ;
                endcase
            end
            S_FSYN: begin
                n_state = S_FLOOP;
                if (r_next == '0 && s_room) begin
                    s_emit = 1'b1; s_track = 1'b1; s_acct = 1'b1; s_syn = 1'b1;
                end
            end
            S_FLOOP: begin
                // one data segment per cycle
                if (r_wl != '0 && r_buf != '0 && s_room) begin
                    if (s_n > 16'(MAX_PAYLOAD)) s_n = 16'(MAX_PAYLOAD);
                    if (s_n > r_buf) s_n = r_buf;
                    s_buf_left = r_buf - s_n;
                    n_buf = s_buf_left;
                    s_pay = LEN_W'(s_n);
                    if (r_ended && s_buf_left == '0 && !r_fin_done && s_n < r_wl) begin
                        s_fin      = 1'b1;
                        n_fin_done = 1'b1;
                    end
                    s_emit = 1'b1; s_track = 1'b1; s_acct = 1'b1;
                end else begin
                    n_state = S_FFIN;
                end
            end
            S_FFIN: begin
                n_state = S_FIN;
                if (r_ended && r_buf == '0 && !r_fin_done && r_wl != '0 && s_room) begin
                    n_fin_done = 1'b1;
                    s_fin = 1'b1; s_emit = 1'b1; s_track = 1'b1; s_acct = 1'b1;
                end
            end
            S_ARD: begin
                if (r_count != '0) begin
                    s_pre   = 1'b1;
                    n_state = S_ACHK;
                end else begin
                    n_state = S_AUPD;
                end
            end
            S_ACHK: begin
                if (s_q_off + OFF_W'(s_q_len) <= r_ack_off) begin
                    // retire oldest segment
                    n_head   = (r_head == IDX_W'(PENDING_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count  = r_count - 1'b1;
                    n_flight = r_flight - FL_W'(s_q_len);
                    n_state  = S_ARD;
                end else begin
                    n_state = S_AUPD;
                end
            end
            S_AUPD: begin
                n_state = S_FSYN;
                if (r_win == '0) begin
                    n_wl = 16'd1;
                    n_wz = 1'b1;
                end else if (s_right > r_hre) begin
                    n_hre = s_right;
                    n_wl  = r_win;
                    n_wz  = 1'b0;
                end
                if (r_ack_off > r_hack) begin
                    n_cto   = s_ito32;
                    n_timer = '0;
                    n_trun  = (r_count != '0);
                    n_retry = '0;
                    n_hack  = r_ack_off;
                end
            end
            S_TRD: begin
                s_pre   = 1'b1;
                n_state = S_TEMIT;
            end
            S_TEMIT: begin
                n_state = S_FIN;
                s_syn   = (s_q_off == '0);
                s_fin   = r_fin_done && (s_q_off + OFF_W'(s_q_len) == r_next);
                s_flags = {1'b0, s_syn} + {1'b0, s_fin};
                s_pay   = (s_q_len < LEN_W'(s_flags)) ? '0 : s_q_len - LEN_W'(s_flags);
                s_seq   = r_iseq + s_q_off[31:0];
                s_rtx   = 1'b1;
                s_emit  = 1'b1;
                s_acct  = 1'b1;
                n_timer = '0;
                if (!r_wz) begin
                    if (r_retry != 8'hFF) n_retry = r_retry + 1'b1;
                    n_cto = r_cto[31] ? 32'hFFFF_FFFF : {r_cto[30:0], 1'b0};
                end
            end
            S_FIN: begin
                n_state          = S_IDLE;
                o_flush.start    = 1'b1;
                o_flush.count    = (r_nres == '0) ? RN_W'(1) : r_nres;
                o_flush.flight   = r_flight;
                o_flush.retry    = r_retry;
                o_flush.accepted = r_accepted;
            end
            default: n_state = S_IDLE;
        endcase

        s_len = (s_rtx ? s_q_len : s_pay) + ((s_rtx) ? '0 : LEN_W'(s_syn) + LEN_W'(s_fin));
        if (s_emit) begin
            n_nres = r_nres + 1'b1;
        end
        if (s_track) begin
            n_count  = r_count + 1'b1;
            n_next   = r_next + OFF_W'(s_len);
            n_flight = r_flight + FL_W'(s_len);
        end
        if (s_acct) begin
            n_wl = (32'(r_wl) < 32'(s_len)) ? '0 : 16'(32'(r_wl) - 32'(s_len));
            if (!r_trun) begin
                n_trun  = 1'b1;
                n_timer = '0;
            end
        end
        if (i_cfg_we && i_cfg_idx == REG_ITO) begin
            n_cto = {16'd0, i_cfg_data[15:0]};
        end
    end

    assign s_pwe    = s_track;
    assign s_pwdata = {r_next, s_len};
    assign s_ito32  = {16'd0, r_ito};

    // status result goes to entry zero when nothing was sent
    always_comb begin
        o_rbuf = '0;
        if (s_emit) begin
            o_rbuf.we       = 1'b1;
            o_rbuf.addr     = RA_W'(r_nres);
            o_rbuf.data.has = 1'b1;
            o_rbuf.data.seq = s_seq;
            o_rbuf.data.pay = s_pay[PAY_W-1:0];
            o_rbuf.data.syn = s_syn;
            o_rbuf.data.fin = s_fin;
            o_rbuf.data.rtx = s_rtx;
        end else if (r_state == S_FIN && r_nres == '0) begin
            o_rbuf.we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_iseq     <= '0;
            r_ito      <= 16'd1000;
            r_cap      <= 16'hFFFF;
            r_next     <= '0;
            r_hack     <= '0;
            r_hre      <= '0;
            r_ack_off  <= '0;
            r_wl       <= 16'd1;
            r_wz       <= 1'b0;
            r_fin_done <= 1'b0;
            r_trun     <= 1'b0;
            r_timer    <= '0;
            r_cto      <= 32'd1000;
            r_retry    <= '0;
            r_buf      <= '0;
            r_ended    <= 1'b0;
            r_head     <= '0;
            r_count    <= '0;
            r_flight   <= '0;
            r_nres     <= '0;
            r_accepted <= '0;
        end else begin
            r_state    <= n_state;
            r_next     <= n_next;
            r_hack     <= n_hack;
            r_hre      <= n_hre;
            r_ack_off  <= n_ack_off;
            r_wl       <= n_wl;
            r_wz       <= n_wz;
            r_fin_done <= n_fin_done;
            r_trun     <= n_trun;
            r_timer    <= n_timer;
            r_cto      <= n_cto;
            r_retry    <= n_retry;
            r_buf      <= n_buf;
            r_ended    <= n_ended;
            r_head     <= n_head;
            r_count    <= n_count;
            r_flight   <= n_flight;
            r_nres     <= n_nres;
            r_accepted <= n_accepted;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ISEQ: r_iseq <= i_cfg_data;
                    REG_ITO:  r_ito  <= i_cfg_data[15:0];
                    REG_CAP:  r_cap  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // latch the input beat
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd     <= i_command;
            r_wcnt    <= i_write_count;
            r_eoi     <= i_end_input;
            r_ackno   <= i_ack_number;
            r_win     <= i_peer_window;
            r_elapsed <= i_elapsed_ms;
        end
    end

    `TSW_NEVER(a_ring_bound, i_clk, i_rst_n, r_count > CNT_W'(PENDING_DEPTH), "ring overfilled")
    `TSW_NEVER(a_res_bound, i_clk, i_rst_n, r_nres > RN_W'(RESULT_LIMIT), "result overflow")
    `TSW_ASSERT(a_empty_flight, i_clk, i_rst_n, (r_count == '0) |-> (r_flight == '0), "flight with empty ring")
    `TSW_ASSERT(a_busy_after, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "second beat taken")

endmodule

// ----- rtl/tcp_sender_window_retransmit.sv -----
// Top level: sender engine, result buffer and result streamer.
//   channel | dir | handshake                 | payload
//   input   | in  | i_in_valid / o_in_ready   | command, counts, ack, window, elapsed
//   output  | out | o_out_valid / i_out_ready | segment descriptor and status
//   config  | in  | i_cfg_we                  | i_cfg_idx, i_cfg_data
// After the accepting edge, write, empty, unknown commands and ticks without a resend
// pass through decode and flush; a resend adds a ring read and an emit step.
// Fill adds the SYN step, a loop step for each segment sent and the FIN step; ack adds
// a ring read and a check for each segment examined, then the window update, then the
// fill. Results then stream from the result buffer, with a read and a show step for
// each beat plus output stalls. Reset is synchronous; no clearing pass. A new item is taken once all results left.
module tcp_sender_window_retransmit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_write_count,
    input  logic        i_end_input,
    input  logic [31:0] i_ack_number,
    input  logic [15:0] i_peer_window,
    input  logic [15:0] i_elapsed_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_has_segment,
    output logic [31:0] o_segment_seqno,
    output logic [10:0] o_payload_length,
    output logic        o_syn_flag,
    output logic        o_fin_flag,
    output logic        o_is_retransmit,
    output logic        o_last_result,
    output logic [31:0] o_flight_bytes,
    output logic [7:0]  o_retransmit_count,
    output logic [15:0] o_accepted_bytes
);
    import tsw_pkg::*;

    typedef enum logic [1:0] {O_IDLE, O_RD, O_SHOW} t_ostate;

    t_ostate         r_ost;
    t_rbuf_wr        s_rbuf;
    t_flush          s_flush;
    t_res            s_q;
    logic            s_re;
    logic [RN_W-1:0] r_idx, r_n;
    logic [FL_W-1:0] r_flight;
    logic [7:0]      r_retry;
    logic [15:0]     r_acc;

    tsw_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_write_count(i_write_count),
        .i_end_input  (i_end_input),
        .i_ack_number (i_ack_number),
        .i_peer_window(i_peer_window),
        .i_elapsed_ms (i_elapsed_ms),
        .i_out_busy   (r_ost != O_IDLE),
        .o_rbuf       (s_rbuf),
        .o_flush      (s_flush)
    );

    assign s_re = (r_ost == O_RD);

    tsw_ram #(.WIDTH($bits(t_res)), .DEPTH(RESULT_LIMIT)) u_rbuf (
        .i_clk  (i_clk),
        .i_we   (s_rbuf.we),
        .i_waddr(s_rbuf.addr),
        .i_wdata(s_rbuf.data),
        .i_re   (s_re),
        .i_raddr(RA_W'(r_idx)),
        .o_rdata(s_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ost <= O_IDLE;
            r_idx <= '0;
        end else begin
            case (r_ost)
                O_IDLE: begin
                    if (s_flush.start) begin
                        r_ost <= O_RD;
                        r_idx <= '0;
                    end
                end
                O_RD: r_ost <= O_SHOW;
                O_SHOW: begin
                    if (i_out_ready) begin
                        if (r_idx == r_n - 1'b1) begin
                            r_ost <= O_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_ost <= O_RD;
                        end
                    end
                end
                default: r_ost <= O_IDLE;
            endcase
        end
    end

    // hold per-item status for every beat
    always_ff @(posedge i_clk) begin
        if (s_flush.start) begin
            r_n      <= s_flush.count;
            r_flight <= s_flush.flight;
            r_retry  <= s_flush.retry;
            r_acc    <= s_flush.accepted;
        end
    end

    assign o_out_valid        = (r_ost == O_SHOW);
    assign o_has_segment      = s_q.has;
    assign o_segment_seqno    = s_q.seq;
    assign o_payload_length   = s_q.pay;
    assign o_syn_flag         = s_q.syn;
    assign o_fin_flag         = s_q.fin;
    assign o_is_retransmit    = s_q.rtx;
    assign o_last_result      = (r_idx == r_n - 1'b1);
    assign o_flight_bytes     = 32'(r_flight);
    assign o_retransmit_count = r_retry;
    assign o_accepted_bytes   = r_acc;

endmodule
